FILE: sv/hsl_to_rgb_converter_core_assert.svh
// Assertion macros for the HSL to RGB converter.
// Included by the modules that check their own pipeline invariants.
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is held
`define HSLRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs through reset
`define HSLRGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSLRGB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSLRGB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/hslrgb_pkg.sv
// Shared constants, types and fixed-point formats for the HSL to RGB converter.
// No dependencies; imported by every module of the block.
package hslrgb_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, one = 2^FRAC_BITS
  localparam int FRAC_BITS = 12;
  localparam int IN_BITS   = 12;
  localparam int FW        = FRAC_BITS + 1;
  localparam int N_STAGES  = 6;

  localparam int unsigned ONE_I = 32'd1 << FRAC_BITS;

  localparam logic [FRAC_BITS:0]   ONE        = FW'(ONE_I);
  localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(ONE_I / 2);
  localparam logic [FRAC_BITS-1:0] THIRD      = FRAC_BITS'(ONE_I / 3);
  localparam logic [FRAC_BITS-1:0] SIXTH      = FRAC_BITS'(ONE_I / 6);
  localparam logic [FRAC_BITS-1:0] TWO_THIRDS = FRAC_BITS'((2 * ONE_I) / 3);

  // Hue offsets per channel, modulo one turn
  localparam logic [FRAC_BITS-1:0] OFS_RED   = THIRD;
  localparam logic [FRAC_BITS-1:0] OFS_GREEN = '0;
  localparam logic [FRAC_BITS-1:0] OFS_BLUE  = FRAC_BITS'(ONE_I - ONE_I / 3);

  typedef logic [FRAC_BITS:0]   unit_t;   // value in [0, one]
  typedef logic [FRAC_BITS-1:0] frac_t;   // value in [0, one)

  // p, q and their difference, with the gray flag and lightness
  typedef struct packed {
    logic  gray;
    unit_t l;
    unit_t p;
    unit_t q;
    unit_t d;
  } qp_t;

  // Per-stage load enables and valid bits
  typedef struct packed {
    logic [N_STAGES-1:0] ld;
    logic [N_STAGES-1:0] vld;
  } pipe_ctl_t;

endpackage

FILE: sv/hslrgb_ctrl.sv
// Pipeline valid/stall control for the HSL to RGB converter.
// Depends on hslrgb_pkg and the assertion header.
`include "hsl_to_rgb_converter_core_assert.svh"

module hslrgb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_stall,
  output logic                  in_stall,
  output hslrgb_pkg::pipe_ctl_t ctl
);
  import hslrgb_pkg::*;

  logic [N_STAGES-1:0] vld_r;
  logic [N_STAGES-1:0] vld_nxt;
  logic [N_STAGES-1:0] rdy;

  // A stage may load when it is empty or the stage after it moves on
  always_comb begin
    rdy[N_STAGES-1] = !vld_r[N_STAGES-1] || !out_stall;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[0];
  assign ctl.ld   = rdy;
  assign ctl.vld  = vld_r;

  // Input only held off when every stage is occupied
  `HSLRGB_ASSERT(a_stall_full, clk, rst_n, in_stall |-> (&vld_r), "input stalled with a bubble")
  // Items in flight change only by what enters and leaves
  `HSLRGB_ASSERT(a_item_count, clk, rst_n, $past(rst_n) |-> ($countones(vld_r) == $past($countones(vld_r)) + int'($past(in_valid && !in_stall)) - int'($past(vld_r[N_STAGES-1] && !out_stall))), "item lost or duplicated")
  // Reset empties the pipeline
  `HSLRGB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (vld_r == '0), "valid bits survive reset")

endmodule

FILE: sv/hslrgb_qp.sv
// Front end of the converter: input clamp, fixed-point scaling, q and p.
// Depends on hslrgb_pkg and the assertion header; stages 1 to 3.
`include "hsl_to_rgb_converter_core_assert.svh"

module hslrgb_qp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  hslrgb_pkg::pipe_ctl_t                   ctl,
  input  logic [hslrgb_pkg::IN_BITS-1:0]          hue,
  input  logic [hslrgb_pkg::IN_BITS:0]            saturation,
  input  logic [hslrgb_pkg::IN_BITS:0]            lightness,
  output hslrgb_pkg::frac_t                       h_fix,
  output hslrgb_pkg::qp_t                         qp
);
  import hslrgb_pkg::*;

  localparam int UP_SHIFT   = (FRAC_BITS >= IN_BITS) ? FRAC_BITS - IN_BITS : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS >= IN_BITS) ? 0 : IN_BITS - FRAC_BITS;
  localparam int MW         = 2 * FRAC_BITS + 3;  // l times (one + s)
  localparam int QW         = FRAC_BITS + 2;
  localparam logic [IN_BITS:0] IN_MAX = (IN_BITS + 1)'(32'd1 << IN_BITS);

  // Input scale (12 fraction bits) moved to FRAC_BITS, truncating
  function automatic unit_t to_fixed(input logic [IN_BITS:0] v);
    logic [IN_BITS+FRAC_BITS:0] w;
    w = (IN_BITS + FRAC_BITS + 1)'(v) << UP_SHIFT;
    w = w >> DOWN_SHIFT;
    return FW'(w);
  endfunction

  // Stage 1: clamp and scale
  logic [IN_BITS:0] s_clamp, l_clamp;
  unit_t            h_wide;
  frac_t            h1_r;
  unit_t            s1_r, l1_r;

  always_comb begin
    s_clamp = (saturation > IN_MAX) ? IN_MAX : saturation;
    l_clamp = (lightness > IN_MAX) ? IN_MAX : lightness;
    h_wide  = to_fixed({1'b0, hue});
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      h1_r <= h_wide[FRAC_BITS-1:0];
      s1_r <= to_fixed(s_clamp);
      l1_r <= to_fixed(l_clamp);
    end
  end

  assign h_fix = h1_r;

  // Stage 2: l * (one + s) below half lightness, l * s above
  logic             lo_nxt;
  logic [QW-1:0]    mul_b;
  logic [MW-1:0]    prod2_r;
  unit_t            l2_r, s2_r;
  logic             lo2_r, gray2_r;

  always_comb begin
    lo_nxt = l1_r < {1'b0, HALF};
    mul_b  = lo_nxt ? (QW'(ONE) + QW'(s1_r)) : QW'(s1_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      prod2_r <= MW'(l1_r) * MW'(mul_b);
      l2_r    <= l1_r;
      s2_r    <= s1_r;
      lo2_r   <= lo_nxt;
      gray2_r <= (s1_r == '0);
    end
  end

  // Stage 3: q, p = 2l - q, d = q - p = 2(q - l)
  logic [QW:0]   prod_sh;
  unit_t         q_nxt, q_l_diff;
  qp_t           qp_nxt, qp_r;

  always_comb begin
    prod_sh  = prod2_r[MW-1:FRAC_BITS];
    q_nxt    = lo2_r ? FW'(prod_sh)
                     : FW'(QW'(l2_r) + QW'(s2_r) - QW'(prod_sh));
    q_l_diff = q_nxt - l2_r;
    qp_nxt.gray = gray2_r;
    qp_nxt.l    = l2_r;
    qp_nxt.q    = q_nxt;
    qp_nxt.p    = FW'({l2_r, 1'b0} - QW'(q_nxt));
    qp_nxt.d    = FW'({q_l_diff, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      qp_r <= qp_nxt;
    end
  end

  assign qp = qp_r;

  // Ramp endpoints stay ordered and within one
  `HSLRGB_ASSERT(a_qp_order, clk, rst_n, (ctl.vld[2] && !qp_r.gray) |-> (qp_r.p <= qp_r.q), "p above q")
  `HSLRGB_ASSERT(a_q_range, clk, rst_n, (ctl.vld[2] && !qp_r.gray) |-> ((qp_r.q <= ONE) && (qp_r.d == qp_r.q - qp_r.p)), "q out of range or d inconsistent")

endmodule

FILE: sv/hslrgb_ramp.sv
// One colour channel: hue offset, piecewise-linear ramp and byte scaling.
// Depends on hslrgb_pkg and the assertion header; stages 2 to 6.
`include "hsl_to_rgb_converter_core_assert.svh"

module hslrgb_ramp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hslrgb_pkg::pipe_ctl_t ctl,
  input  hslrgb_pkg::frac_t     hue_ofs,
  input  hslrgb_pkg::frac_t     h_fix,
  input  hslrgb_pkg::qp_t       qp,
  output logic [7:0]            chan
);
  import hslrgb_pkg::*;

  localparam int PW = 2 * FRAC_BITS + 1;  // d times 6t

  typedef enum logic [1:0] {
    RG_RISE = 2'd0,
    RG_FLAT = 2'd1,
    RG_FALL = 2'd2,
    RG_LOW  = 2'd3
  } region_t;

  function automatic frac_t times6(input frac_t x);
    logic [FRAC_BITS+2:0] w;
    w = ((FRAC_BITS + 3)'(x) << 2) + ((FRAC_BITS + 3)'(x) << 1);
    return w[FRAC_BITS-1:0];
  endfunction

  // floor(255 * v / one), saturated
  function automatic logic [7:0] to_byte(input unit_t v);
    logic [FRAC_BITS+8:0] m;
    logic [8:0]           c;
    m = {v, 8'd0} - (FRAC_BITS + 9)'(v);
    c = m[FRAC_BITS+8:FRAC_BITS];
    return (c > 9'd255) ? 8'hFF : c[7:0];
  endfunction

  // Stage 2: wrapped hue for this channel
  frac_t t2_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      t2_r <= h_fix + hue_ofs;
    end
  end

  // Stage 3: ramp region and slope factor
  region_t rg3_nxt, rg3_r;
  frac_t   f3_nxt, f3_r;

  always_comb begin
    if (t2_r < SIXTH) begin
      rg3_nxt = RG_RISE;
      f3_nxt  = times6(t2_r);
    end else if (t2_r < HALF) begin
      rg3_nxt = RG_FLAT;
      f3_nxt  = '0;
    end else if (t2_r < TWO_THIRDS) begin
      rg3_nxt = RG_FALL;
      f3_nxt  = times6(TWO_THIRDS - t2_r);
    end else begin
      rg3_nxt = RG_LOW;
      f3_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      rg3_r <= rg3_nxt;
      f3_r  <= f3_nxt;
    end
  end

  // Stage 4: slope product
  logic [PW-1:0] prod4_r;
  region_t       rg4_r;
  unit_t         p4_r, q4_r, l4_r;
  logic          gray4_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      prod4_r <= PW'(qp.d) * PW'(f3_r);
      rg4_r   <= rg3_r;
      p4_r    <= qp.p;
      q4_r    <= qp.q;
      l4_r    <= qp.l;
      gray4_r <= qp.gray;
    end
  end

  // Stage 5: ramp value, or lightness for gray
  unit_t v5_nxt, v5_r;

  always_comb begin
    if (gray4_r) begin
      v5_nxt = l4_r;
    end else begin
      case (rg4_r)
        RG_RISE, RG_FALL: v5_nxt = p4_r + prod4_r[PW-1:FRAC_BITS];
        RG_FLAT:          v5_nxt = q4_r;
        RG_LOW:           v5_nxt = p4_r;
        default:          v5_nxt = p4_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      v5_r <= v5_nxt;
    end
  end

  // Stage 6: byte scaling into the output register
  logic [7:0] chan_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      chan_r <= to_byte(v5_r);
    end
  end

  assign chan = chan_r;

  // Channel value never exceeds one before scaling
  `HSLRGB_ASSERT(a_value_range, clk, rst_n, ctl.vld[4] |-> (v5_r <= ONE), "ramp value above one")

endmodule

FILE: sv/hsl_to_rgb_converter_core.sv
// Top level of the HSL to RGB converter: control, front end and three channels.
// Depends on hslrgb_pkg, hslrgb_ctrl, hslrgb_qp and hslrgb_ramp.
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_stall  in_hue[11:0] in_saturation[12:0] in_lightness[12:0]
//  out      out_valid / out_stall out_red[7:0] out_green[7:0] out_blue[7:0]
//
// Six register stages; one item per clock while out_stall is low; out_valid rises when
// the item reaches the last stage. Stages: scale, l*(one+s) or l*s product, q/p and
// hue region, slope product, ramp sum, byte scaling.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds under stall only when full; bubbles close up, so items keep
// being taken while a result waits at the output.

module hsl_to_rgb_converter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hslrgb_pkg::IN_BITS-1:0]       in_hue,
  input  logic [hslrgb_pkg::IN_BITS:0]         in_saturation,
  input  logic [hslrgb_pkg::IN_BITS:0]         in_lightness,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue
);
  import hslrgb_pkg::*;

  pipe_ctl_t ctl;
  frac_t     h_fix;
  qp_t       qp;

  // Stage valid and load control
  hslrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctl       (ctl)
  );

  assign out_valid = ctl.vld[N_STAGES-1];

  // Shared q/p front end
  hslrgb_qp u_qp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .hue        (in_hue),
    .saturation (in_saturation),
    .lightness  (in_lightness),
    .h_fix      (h_fix),
    .qp         (qp)
  );

  // One ramp per colour channel
  hslrgb_ramp u_ramp_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .hue_ofs (OFS_RED),
    .h_fix   (h_fix),
    .qp      (qp),
    .chan    (out_red)
  );

  hslrgb_ramp u_ramp_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .hue_ofs (OFS_GREEN),
    .h_fix   (h_fix),
    .qp      (qp),
    .chan    (out_green)
  );

  hslrgb_ramp u_ramp_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .hue_ofs (OFS_BLUE),
    .h_fix   (h_fix),
    .qp      (qp),
    .chan    (out_blue)
  );

endmodule

FILE: verif/hsl_to_rgb_converter_core_test.sv
// Self-checking testbench for hsl_to_rgb_converter_core: directed and random HSL pixels,
// with an RGB predictor and a scoreboard class. Random idling on both channels.
// Depends on hslrgb_pkg and hsl_to_rgb_converter_core.
module hsl_to_rgb_converter_core_test;

  localparam int FB = hslrgb_pkg::FRAC_BITS;
  localparam int IB = hslrgb_pkg::IN_BITS;
  localparam int TURN = 1 << IB;
  localparam int N_RANDOM = 1400;
  localparam int PHASE_LEN = 175;
  localparam int DRAIN_CYCLES = 4 * hslrgb_pkg::N_STAGES;
  localparam int CYCLE_LIMIT = 400000;

  // Fixed-point working values, wide enough for every product
  typedef bit [63:0] wide_t;
  localparam wide_t UNIT = wide_t'(1) << FB;
  localparam wide_t THIRD_U = UNIT / 3;
  localparam wide_t SIXTH_U = UNIT / 6;
  localparam wide_t HALF_U = UNIT / 2;
  localparam wide_t TWO3_U = (2 * UNIT) / 3;
  localparam int UP_SH = (FB >= IB) ? FB - IB : 0;
  localparam int DN_SH = (FB >= IB) ? 0 : IB - FB;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Which side idles during a phase
  typedef enum logic [1:0] {PACE_FREE, PACE_SRC, PACE_SINK, PACE_BOTH} pace_t;

  // Predicts the RGB pixel of each accepted item and checks results in order
  class rgb_scoreboard;
    rgb_t pending_rgb[$];
    int mismatches = 0;

    static function wide_t to_unit(wide_t raw);
      return (raw << UP_SH) >> DN_SH;
    endfunction

    // Piecewise-linear hue ramp between p and q
    static function wide_t hue_ramp(wide_t p, wide_t q, wide_t t);
      if (t < SIXTH_U) return p + (((q - p) * 6 * t) >> FB);
      if (t < HALF_U) return q;
      if (t < TWO3_U) return p + (((q - p) * 6 * (TWO3_U - t)) >> FB);
      return p;
    endfunction

    static function logic [7:0] scale_byte(wide_t v);
      wide_t c;
      c = (wide_t'(255) * v) >> FB;
      return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function rgb_t rgb_of_hsl(logic [IB-1:0] h_in, logic [IB:0] s_in, logic [IB:0] l_in);
      wide_t h, s, l, q, p;
      rgb_t px;
      h = to_unit(wide_t'(h_in));
      s = to_unit((s_in > TURN) ? wide_t'(TURN) : wide_t'(s_in));
      l = to_unit((l_in > TURN) ? wide_t'(TURN) : wide_t'(l_in));
      // no saturation: plain gray
      if (s == 0) begin
        px.red = scale_byte(l);
        px.green = px.red;
        px.blue = px.red;
        return px;
      end
      if (l < HALF_U) q = (l * (UNIT + s)) >> FB;
      else q = l + s - ((l * s) >> FB);
      p = 2 * l - q;
      px.red = scale_byte(hue_ramp(p, q, (h + THIRD_U) & (UNIT - 1)));
      px.green = scale_byte(hue_ramp(p, q, h & (UNIT - 1)));
      px.blue = scale_byte(hue_ramp(p, q, (h + UNIT - THIRD_U) & (UNIT - 1)));
      return px;
    endfunction

    function void note_pixel(logic [IB-1:0] h, logic [IB:0] s, logic [IB:0] l);
      pending_rgb.push_back(rgb_of_hsl(h, s, l));
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        report($sformatf("pixel %0d/%0d/%0d with nothing pending", r, g, b));
        return;
      end
      want = pending_rgb.pop_front();
      if (r !== want.red) report($sformatf("red %0d, want %0d", r, want.red));
      if (g !== want.green) report($sformatf("green %0d, want %0d", g, want.green));
      if (b !== want.blue) report($sformatf("blue %0d, want %0d", b, want.blue));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [IB-1:0] in_hue;
  logic [IB:0] in_saturation;
  logic [IB:0] in_lightness;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  rgb_scoreboard sb = new();
  pace_t pace = PACE_FREE;
  int cycles = 0;

  hsl_to_rgb_converter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_hue(in_hue),
    .in_saturation(in_saturation),
    .in_lightness(in_lightness),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  always #2 clk = ~clk;

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len(bit active);
    int r;
    if (!active) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Saturation or lightness: zero, one, over-range, near half, or anywhere
  function automatic logic [IB:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return (IB + 1)'(TURN);
    if (r < 24) return (IB + 1)'($urandom_range(TURN + 1, 2 * TURN - 1));
    if (r < 30) return (IB + 1)'($urandom_range(TURN / 2 - 8, TURN / 2 + 8));
    return (IB + 1)'($urandom_range(1, TURN - 1));
  endfunction

  // Hue: ramp boundaries now and then, otherwise uniform
  function automatic logic [IB-1:0] pick_hue();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 7))
        0: return IB'(TURN / 6);
        1: return IB'(TURN / 6 - 1);
        2: return IB'(TURN / 3);
        3: return IB'(TURN / 3 + 1);
        4: return IB'(TURN / 2);
        5: return IB'((2 * TURN) / 3);
        6: return IB'(TURN - TURN / 3);
        default: return IB'(TURN - 1);
      endcase
    end
    return IB'($urandom_range(0, TURN - 1));
  endfunction

  // Present one item and hold it until taken
  task automatic send_pixel(input int h, input int s, input int l);
    in_valid <= 1'b1;
    in_hue <= IB'(h);
    in_saturation <= (IB + 1)'(s);
    in_lightness <= (IB + 1)'(l);
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_pixel(IB'(h), (IB + 1)'(s), (IB + 1)'(l));
  endtask

  // Result side: take and check each accepted item
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_rgb(out_red, out_green, out_blue);
  end

  // Overall cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[hsl_to_rgb_converter_core] ERROR");
      $finish;
    end
  end

  // Receiver stalls, paced by the current phase
  initial begin : sink_pacing
    int n;
    forever begin
      n = idle_len(pace == PACE_SINK || pace == PACE_BOTH);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : source
    int gap;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_hue <= '0;
    in_saturation <= '0;
    in_lightness <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, gray, primaries, ramp boundaries, clamping
    send_pixel(0, 0, 0);
    send_pixel(TURN - 1, 2 * TURN - 1, 2 * TURN - 1);
    send_pixel(0, 0, TURN);
    send_pixel(1234, 0, TURN / 2);
    send_pixel(0, 0, 2 * TURN - 1);
    send_pixel(0, TURN, TURN / 2);
    send_pixel(TURN / 3, TURN, TURN / 2);
    send_pixel(TURN - TURN / 3, TURN, TURN / 2);
    send_pixel(TURN / 6, TURN, TURN / 2);
    send_pixel(TURN / 6 + 1, TURN, TURN / 2);
    send_pixel(TURN / 2, TURN, TURN / 2);
    send_pixel((2 * TURN) / 3, TURN, TURN / 2);
    send_pixel(TURN - 1, TURN, TURN / 2);
    send_pixel(300, TURN, TURN / 2 - 1);
    send_pixel(300, 2000, TURN / 2);
    send_pixel(300, TURN, TURN);
    send_pixel(300, 1, 1);
    send_pixel(3000, 8000, 1000);
    send_pixel(100, TURN, TURN - 1);
    send_pixel(TURN / 3, 1, TURN - 1);

    // Random items, idling pattern rotating by phase
    for (int i = 0; i < N_RANDOM; i++) begin
      pace = pace_t'((i / PHASE_LEN) % 4);
      gap = idle_len(pace == PACE_SRC || pace == PACE_BOTH);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_pixel(int'(pick_hue()), int'(pick_level()), int'(pick_level()));
    end
    in_valid <= 1'b0;

    // Drain, then allow for stray results
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_rgb.size() == 0)
      $display("[hsl_to_rgb_converter_core] OK");
    else
      $display("[hsl_to_rgb_converter_core] ERROR");
    $finish;
  end

endmodule
